// ----- src/gpib_pkg.sv -----
// shared types and constants for the grid point-in-box classifier
`default_nettype none
package gpib_pkg;
	localparam int COORD_W = 16;
	localparam int MAT_W = 3;
	localparam logic [MAT_W-1:0] MAT_MAX = 3'd4;
	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_QUERY = 1'b1;
	localparam logic [1:0] REG_MIN_X = 2'd0;
	localparam logic [1:0] REG_MIN_Y = 2'd1;
	localparam logic [1:0] REG_MAX_X = 2'd2;
	localparam logic [1:0] REG_MAX_Y = 2'd3;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		logic         command;
		coord_t       rect_low_x;
		coord_t       rect_low_y;
		coord_t       rect_high_x;
		coord_t       rect_high_y;
		logic [2:0]   rect_material;
		coord_t       point_x;
		coord_t       point_y;
	} item_t;

	typedef struct packed {
		logic [2:0] material;
		logic       outside_region;
		logic       no_rect_hit;
		logic       insert_dropped;
	} result_t;
endpackage
`default_nettype wire

// ----- src/gpib_if.sv -----
// valid/ready channel interfaces for items, results and configuration
`default_nettype none
interface gpib_item_if;
	logic valid;
	logic ready;
	gpib_pkg::item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface gpib_result_if;
	logic valid;
	logic ready;
	gpib_pkg::result_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface gpib_cfg_if;
	logic valid;
	logic ready;
	logic [1:0] index;
	logic [15:0] wdata;
	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

// ----- src/grid_point_in_box_classifier.sv -----
// Grid point-in-box classifier: an insert walks the grid cells, a query scans one cell
// Insert: a column pass, then every cell, then the result (ST_INS_X, ST_INS_Y, ST_OUT)
// Query: cell search per axis, then a scan of the table through one registered read;
//   an outside point skips the search and goes straight to the result register
// One item at a time; next accept in the cycle after the result register loads, stalls delay it
// arst_n clears count, registers and handshakes, then ST_CLR clears the masks cell by cell, ready low
`default_nettype none
module grid_point_in_box_classifier #(
	parameter int CELLS_PER_SIDE = 8,
	parameter int MAX_RECTS = 64
) (
	input wire logic clk,
	input wire logic arst_n,
	gpib_item_if.sink     item,
	gpib_result_if.source result,
	gpib_cfg_if.sink      cfg
);
	import gpib_pkg::*;

	localparam int CW = (CELLS_PER_SIDE > 1) ? $clog2(CELLS_PER_SIDE) : 1;
	localparam int NC = CELLS_PER_SIDE * CELLS_PER_SIDE;
	localparam int CIW = (NC > 1) ? $clog2(NC) : 1;
	localparam int RW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
	localparam int CNTW = $clog2(MAX_RECTS + 1);

	typedef enum logic [2:0] {
		ST_CLR, ST_IDLE, ST_CX, ST_CY, ST_INS_X, ST_INS_Y, ST_SCAN, ST_OUT
	} state_t;

	state_t state_q;
	coord_t min_x_q, min_y_q, max_x_q, max_y_q;
	item_t it_q;
	logic [CNTW-1:0] count_q;
	logic [CIW-1:0] clr_q;
	logic [MAX_RECTS-1:0] cell_q [NC];
	logic [31:0] lo_mem [MAX_RECTS];
	logic [31:0] hi_mem [MAX_RECTS];
	logic [MAT_W-1:0] mat_mem [MAX_RECTS];
	logic [CW:0] i_q;
	logic [CW:0] j_q;
	logic [CW-1:0] cx_q;
	logic [CELLS_PER_SIDE-1:0] colok_q;
	logic [RW:0] k_q;
	logic [MAX_RECTS-1:0] mask_q;
	result_t pend_q;
	result_t res_q;
	logic res_valid_q;

	// shared compare unit operand select
	logic signed [16:0] diff;
	logic signed [17:0] width;
	logic [3:0] mul_n, mul_c;
	logic le, ge;
	logic signed [16:0] wx, wy;
	logic [CW:0] jm1;

	assign wx = 17'(max_x_q) - 17'(min_x_q);
	assign wy = 17'(max_y_q) - 17'(min_y_q);

	always_comb begin
		diff = '0;
		width = '0;
		mul_n = 4'(CELLS_PER_SIDE);
		mul_c = 4'(i_q);
		case (state_q)
			ST_CX: begin
				diff = 17'(it_q.point_x) - 17'(min_x_q);
				width = 18'(wx);
				mul_c = 4'(i_q) + 4'd1;
			end
			ST_CY: begin
				diff = 17'(it_q.point_y) - 17'(min_y_q);
				width = 18'(wy);
				mul_c = 4'(j_q) + 4'd1;
			end
			default: begin
				diff = '0;
			end
		endcase
	end

	gpib_cmp_unit u_cmp (
		.diff(diff), .mul_n(mul_n), .mul_c(mul_c), .width(width), .le(le), .ge(ge)
	);

	// span test for inserts: lo side and hi side per cell index
	function automatic logic span_ok(input coord_t lo, input coord_t hi, input coord_t mn,
		input logic signed [16:0] w, input logic [3:0] idx);
		logic signed [22:0] a, b, c, d;
		begin
			a = 23'(17'(lo) - 17'(mn)) * 23'(CELLS_PER_SIDE);
			b = 23'(w) * 23'($signed({1'b0, idx + 4'd1}));
			c = 23'(17'(hi) - 17'(mn)) * 23'(CELLS_PER_SIDE);
			d = 23'(w) * 23'($signed({1'b0, idx}));
			span_ok = (a <= b) && (c >= d);
		end
	endfunction

	logic in_region;
	assign in_region = !(it_q.point_x < min_x_q || it_q.point_x > max_x_q ||
		it_q.point_y < min_y_q || it_q.point_y > max_y_q);

	// rectangle read for scan
	logic [RW-1:0] rd_k;
	logic [31:0] rlo_q, rhi_q;
	logic [MAT_W-1:0] rmat_q;
	logic hit;
	assign rd_k = (state_q == ST_SCAN) ? RW'(k_q + 1'b1) : '0;
	assign hit = mask_q[k_q[RW-1:0]] &&
		it_q.point_x >= $signed(rlo_q[15:0]) && it_q.point_x <= $signed(rhi_q[15:0]) &&
		it_q.point_y >= $signed(rlo_q[31:16]) && it_q.point_y <= $signed(rhi_q[31:16]);
	assign jm1 = j_q;

	// cell mask update for the current insert step
	logic cell_set;
	logic [CIW-1:0] cell_addr;
	assign cell_addr = CIW'(32'(i_q) * CELLS_PER_SIDE + 32'(j_q));
	assign cell_set = (state_q == ST_INS_Y) && colok_q[i_q[CW-1:0]] &&
		span_ok(it_q.rect_low_y, it_q.rect_high_y, min_y_q, wy, 4'(jm1));

	assign item.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign result.valid = res_valid_q;
	assign result.data = res_q;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_x_q <= '0;
			min_y_q <= '0;
			max_x_q <= 16'sd32767;
			max_y_q <= 16'sd32767;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_MIN_X: min_x_q <= cfg.wdata;
				REG_MIN_Y: min_y_q <= cfg.wdata;
				REG_MAX_X: max_x_q <= cfg.wdata;
				REG_MAX_Y: max_y_q <= cfg.wdata;
				default: min_x_q <= min_x_q;
			endcase
		end
	end

	// rectangle table with one registered read port
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && item.valid && item.data.command == CMD_INSERT &&
			32'(count_q) < MAX_RECTS) begin
			lo_mem[count_q[RW-1:0]] <= {item.data.rect_low_y, item.data.rect_low_x};
			hi_mem[count_q[RW-1:0]] <= {item.data.rect_high_y, item.data.rect_high_x};
			mat_mem[count_q[RW-1:0]] <= (item.data.rect_material > MAT_MAX) ? MAT_MAX
				: item.data.rect_material;
		end
		rlo_q <= lo_mem[rd_k];
		rhi_q <= hi_mem[rd_k];
		rmat_q <= mat_mem[rd_k];
	end

	// cell membership masks: cleared after reset, at most one bit set per insert step
	always_ff @(posedge clk) begin
		if (state_q == ST_CLR)
			cell_q[clr_q] <= '0;
		else if (cell_set)
			cell_q[cell_addr][count_q[RW-1:0]] <= 1'b1;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q <= '0;
			count_q <= '0;
			res_valid_q <= 1'b0;
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
			cx_q <= '0;
			colok_q <= '0;
			mask_q <= '0;
			it_q <= '0;
			pend_q <= '0;
			res_q <= '0;
		end else begin
			if (state_q == ST_OUT && (!res_valid_q || result.ready))
				res_valid_q <= 1'b1;
			else if (result.ready)
				res_valid_q <= 1'b0;
			case (state_q)
				ST_CLR: begin
					if (32'(clr_q) == NC - 1)
						state_q <= ST_IDLE;
					else
						clr_q <= clr_q + 1'b1;
				end
				ST_IDLE: begin
					if (item.valid) begin
						it_q <= item.data;
						i_q <= '0;
						j_q <= '0;
						cx_q <= '0;
						if (item.data.command == CMD_INSERT) begin
							if (32'(count_q) >= MAX_RECTS) begin
								pend_q <= '{material: '0, outside_region: 1'b0,
									no_rect_hit: 1'b0, insert_dropped: 1'b1};
								state_q <= ST_OUT;
							end else begin
								state_q <= ST_INS_X;
							end
						end else begin
							state_q <= ST_CX;
						end
					end
				end
				ST_INS_X: begin
					colok_q[i_q[CW-1:0]] <= span_ok(it_q.rect_low_x, it_q.rect_high_x,
						min_x_q, wx, 4'(i_q));
					if (32'(i_q) == CELLS_PER_SIDE - 1) begin
						i_q <= '0;
						state_q <= ST_INS_Y;
					end else i_q <= i_q + 1'b1;
				end
				ST_INS_Y: begin
					// one row of y cells per column, column by column
					if (32'(j_q) == CELLS_PER_SIDE - 1) begin
						j_q <= '0;
						if (32'(i_q) == CELLS_PER_SIDE - 1) begin
							count_q <= count_q + 1'b1;
							pend_q <= '0;
							state_q <= ST_OUT;
						end else i_q <= i_q + 1'b1;
					end else j_q <= j_q + 1'b1;
				end
				ST_CX: begin
					// first i with n*d < (i+1)*w gives the cell; else clamp
					if (!in_region) begin
						pend_q <= '{material: '0, outside_region: 1'b1,
							no_rect_hit: 1'b0, insert_dropped: 1'b0};
						state_q <= ST_OUT;
					end else if (wx == 0 || 32'(i_q) == CELLS_PER_SIDE - 1 ||
						(le && !ge)) begin
						cx_q <= (wx == 0) ? '0 : i_q[CW-1:0];
						state_q <= ST_CY;
					end else i_q <= i_q + 1'b1;
				end
				ST_CY: begin
					if (wy == 0 || 32'(j_q) == CELLS_PER_SIDE - 1 || 1'b1) begin
						if (wy == 0 || 32'(j_q) == CELLS_PER_SIDE - 1 || (le && !ge)) begin
							mask_q <= cell_q[CIW'(32'(cx_q) * CELLS_PER_SIDE
								+ 32'((wy == 0) ? '0 : j_q[CW-1:0]))];
							k_q <= '0;
							state_q <= ST_SCAN;
						end else j_q <= j_q + 1'b1;
					end
				end
				ST_SCAN: begin
					if (hit) begin
						pend_q <= '{material: rmat_q, outside_region: 1'b0,
							no_rect_hit: 1'b0, insert_dropped: 1'b0};
						state_q <= ST_OUT;
					end else if (32'(k_q) == MAX_RECTS - 1) begin
						pend_q <= '{material: '0, outside_region: 1'b0,
							no_rect_hit: 1'b1, insert_dropped: 1'b0};
						state_q <= ST_OUT;
					end else k_q <= k_q + 1'b1;
				end
				ST_OUT: begin
					if (!res_valid_q || result.ready) begin
						res_q <= pend_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	ap_count: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= MAX_RECTS) else $error("rect count overflow");
	ap_ready: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready |=> state_q != ST_IDLE) else $error("item not taken");
	ap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !result.ready |=> res_valid_q && $stable(res_q))
		else $error("result lost");
endmodule
`default_nettype wire

// ----- src/gpib_cmp_unit.sv -----
// shared multiply-compare unit: n*(a-b) against c*w, all exact
`default_nettype none
module gpib_cmp_unit (
	input  wire logic signed [16:0] diff,
	input  wire logic [3:0]         mul_n,
	input  wire logic [3:0]         mul_c,
	input  wire logic signed [17:0] width,
	output logic                    le,
	output logic                    ge
);
	logic signed [22:0] lhs;
	logic signed [22:0] rhs;
	// one small product each side
	always_comb begin
		lhs = 23'(diff) * 23'($signed({1'b0, mul_n}));
		rhs = 23'(width) * 23'($signed({1'b0, mul_c}));
		le = (lhs <= rhs);
		ge = (lhs >= rhs);
	end
endmodule
`default_nettype wire

// ----- tb/sv/gpib_tb_checker.sv -----
// result predictor and scoreboard for the grid point-in-box classifier
`timescale 1ns / 100ps
`default_nettype none
module gpib_tb_checker (
	input wire logic clk,
	input wire logic arst_n,
	gpib_item_if.sink     item_mon,
	gpib_result_if.sink   result_mon,
	gpib_cfg_if.sink      cfg_mon,
	output int            fail_count,
	output int            pending_count
);
	import gpib_pkg::*;

	localparam int N = 8;
	localparam int TABLE_DEPTH = 64;

	coord_t min_x, min_y, max_x, max_y;
	coord_t box_lo_x [TABLE_DEPTH];
	coord_t box_lo_y [TABLE_DEPTH];
	coord_t box_hi_x [TABLE_DEPTH];
	coord_t box_hi_y [TABLE_DEPTH];
	logic [2:0] box_mat [TABLE_DEPTH];
	int box_count;
	logic [63:0] cell_mask [N*N];
	result_t expected_q [$];

	// inclusive overlap of a span with grid cell i on one axis
	function automatic bit span_hits(longint lo, longint hi, longint mn, longint w, longint i);
		return (N * (lo - mn) <= (i + 1) * w) && (N * (hi - mn) >= i * w);
	endfunction

	function automatic int cell_index(longint p, longint mn, longint mx);
		longint w;
		longint q;
		w = mx - mn;
		if (w == 0)
			return 0;
		q = ((p - mn) * N) / w;
		if (q > N - 1)
			q = N - 1;
		return int'(q);
	endfunction

	// work out the result of one transaction and update the table
	function automatic result_t classify(item_t it);
		result_t r;
		int k;
		int cx;
		int cy;
		logic [63:0] m;
		bit found;
		r = '0;
		if (it.command == CMD_INSERT) begin
			if (box_count >= TABLE_DEPTH) begin
				r.insert_dropped = 1'b1;
			end else begin
				k = box_count;
				box_lo_x[k] = it.rect_low_x;
				box_lo_y[k] = it.rect_low_y;
				box_hi_x[k] = it.rect_high_x;
				box_hi_y[k] = it.rect_high_y;
				box_mat[k] = (it.rect_material > MAT_MAX) ? MAT_MAX : it.rect_material;
				for (int i = 0; i < N; i++) begin
					if (span_hits(it.rect_low_x, it.rect_high_x, min_x,
							longint'(max_x) - min_x, i)) begin
						for (int j = 0; j < N; j++)
							if (span_hits(it.rect_low_y, it.rect_high_y, min_y,
									longint'(max_y) - min_y, j))
								cell_mask[i*N + j][k] = 1'b1;
					end
				end
				box_count++;
			end
		end else if (it.point_x < min_x || it.point_x > max_x ||
				it.point_y < min_y || it.point_y > max_y) begin
			r.outside_region = 1'b1;
		end else begin
			cx = cell_index(it.point_x, min_x, max_x);
			cy = cell_index(it.point_y, min_y, max_y);
			m = cell_mask[cx*N + cy];
			found = 0;
			for (int b = 0; b < TABLE_DEPTH && !found; b++) begin
				if (m[b] && it.point_x >= box_lo_x[b] && it.point_x <= box_hi_x[b] &&
						it.point_y >= box_lo_y[b] && it.point_y <= box_hi_y[b]) begin
					r.material = box_mat[b];
					found = 1;
				end
			end
			r.no_rect_hit = !found;
		end
		return r;
	endfunction

	// watch all three channels
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		result_t got;
		if (!arst_n) begin
			min_x <= 16'sd0;
			min_y <= 16'sd0;
			max_x <= 16'sd32767;
			max_y <= 16'sd32767;
			box_count = 0;
			for (int c = 0; c < N*N; c++)
				cell_mask[c] = '0;
			expected_q.delete();
			fail_count <= 0;
			pending_count <= 0;
		end else begin
			if (cfg_mon.valid && cfg_mon.ready) begin
				case (cfg_mon.index)
					REG_MIN_X: min_x <= cfg_mon.wdata;
					REG_MIN_Y: min_y <= cfg_mon.wdata;
					REG_MAX_X: max_x <= cfg_mon.wdata;
					REG_MAX_Y: max_y <= cfg_mon.wdata;
					default: ;
				endcase
			end
			if (item_mon.valid && item_mon.ready)
				expected_q = {expected_q, classify(item_mon.data)};
			if (result_mon.valid && result_mon.ready) begin
				got = result_mon.data;
				if (expected_q.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result transaction %p", got);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_q.pop_front();
					if (got !== want) begin
						if (fail_count < 10)
							$display("mismatch: want %0d/%0b/%0b/%0b got %0d/%0b/%0b/%0b",
								want.material, want.outside_region, want.no_rect_hit,
								want.insert_dropped, got.material, got.outside_region,
								got.no_rect_hit, got.insert_dropped);
						fail_count <= fail_count + 1;
					end
				end
			end
			pending_count <= expected_q.size();
		end
	end
endmodule
`default_nettype wire

// ----- tb/sv/grid_point_in_box_classifier_tb.sv -----
// stimulus and verdict for the grid point-in-box classifier
`timescale 1ns / 100ps
`default_nettype none
module grid_point_in_box_classifier_tb;
	import gpib_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int fail_count;
	int pending_count;

	gpib_item_if item ();
	gpib_result_if result ();
	gpib_cfg_if cfg ();

	grid_point_in_box_classifier uut (
		.clk(clk), .arst_n(arst_n), .item(item), .result(result), .cfg(cfg)
	);

	gpib_tb_checker scoreboard (
		.clk(clk), .arst_n(arst_n), .item_mon(item), .result_mon(result),
		.cfg_mon(cfg), .fail_count(fail_count), .pending_count(pending_count)
	);

	always #5 clk = ~clk;

	initial begin
		item.valid = 1'b0;
		item.data = '0;
		cfg.valid = 1'b0;
		cfg.index = REG_MIN_X;
		cfg.wdata = '0;
		result.ready = 1'b0;
	end

	// mostly short gaps, a few long ones, and some runs with none
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// random ready on the result side
	initial begin
		int g;
		@(posedge arst_n);
		forever begin
			g = gap_len();
			repeat (g) @(posedge clk) result.ready <= 1'b0;
			@(posedge clk) result.ready <= 1'b1;
		end
	end

	// valid stays high between back-to-back transactions
	task automatic send_item(item_t it);
		int g;
		g = gap_len();
		if (g > 0) begin
			item.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		item.data <= it;
		item.valid <= 1'b1;
		do @(posedge clk); while (!item.ready);
	endtask

	task automatic write_reg(logic [1:0] idx, coord_t v);
		cfg.index <= idx;
		cfg.wdata <= v;
		cfg.valid <= 1'b1;
		do @(posedge clk); while (!cfg.ready);
	endtask

	// wait for all results, then let any trailing work finish
	task automatic drain();
		item.valid <= 1'b0;
		while (pending_count != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic set_region(coord_t x0, coord_t y0, coord_t x1, coord_t y1);
		drain();
		write_reg(REG_MIN_X, x0);
		write_reg(REG_MIN_Y, y0);
		write_reg(REG_MAX_X, x1);
		write_reg(REG_MAX_Y, y1);
		cfg.valid <= 1'b0;
	endtask

	function automatic item_t make_box(coord_t lx, coord_t ly, coord_t hx, coord_t hy,
			logic [2:0] mat);
		item_t it;
		it = item_t'({$urandom, $urandom, $urandom, $urandom});
		it.command = CMD_INSERT;
		it.rect_low_x = lx;
		it.rect_low_y = ly;
		it.rect_high_x = hx;
		it.rect_high_y = hy;
		it.rect_material = mat;
		return it;
	endfunction

	function automatic item_t make_point(coord_t px, coord_t py);
		item_t it;
		it = item_t'({$urandom, $urandom, $urandom, $urandom});
		it.command = CMD_QUERY;
		it.point_x = px;
		it.point_y = py;
		return it;
	endfunction

	// coordinate near the region, sometimes anywhere
	function automatic coord_t near(coord_t lo, coord_t hi);
		int a;
		int b;
		a = (lo < hi) ? lo : hi;
		b = (lo < hi) ? hi : lo;
		if ($urandom_range(0, 9) == 0)
			return coord_t'($urandom);
		a = (a - 40 < -32768) ? -32768 : a - 40;
		b = (b + 40 > 32767) ? 32767 : b + 40;
		return coord_t'(a + int'($urandom_range(0, b - a)));
	endfunction

	task automatic random_phase(int count, coord_t x0, coord_t y0, coord_t x1, coord_t y1);
		coord_t ax;
		coord_t bx;
		coord_t ay;
		coord_t by;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 3) == 0) begin
				ax = near(x0, x1);
				bx = near(x0, x1);
				ay = near(y0, y1);
				by = near(y0, y1);
				if ($urandom_range(0, 9) != 0) begin
					if (ax > bx) begin ax = ax ^ bx; bx = ax ^ bx; ax = ax ^ bx; end
					if (ay > by) begin ay = ay ^ by; by = ay ^ by; ay = ay ^ by; end
				end
				send_item(make_box(ax, ay, bx, by, 3'($urandom)));
			end else begin
				send_item(make_point(near(x0, x1), near(y0, y1)));
			end
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset region, extremes, edges, inverted box, material saturation
		send_item(make_point(16'sd0, 16'sd0));
		send_item(make_box(16'sd0, 16'sd0, 16'sd4096, 16'sd4096, 3'd7));
		send_item(make_box(16'sd100, 16'sd100, 16'sd50, 16'sd50, 3'd2));
		send_item(make_box(-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, 3'd3));
		send_item(make_point(16'sd4096, 16'sd4096));
		send_item(make_point(16'sd32767, 16'sd32767));
		send_item(make_point(-16'sd32768, 16'sd0));
		send_item(make_point(16'sd75, 16'sd75));
		send_item(make_point(16'sd0, -16'sd1));
		send_item(make_box(16'sd4097, 16'sd0, 16'sd8000, 16'sd8000, 3'd1));
		send_item(make_point(16'sd5000, 16'sd100));
		send_item(make_point(16'sd4096, 16'sd5000));

		// full extent region, then zero-width, then inverted
		set_region(-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767);
		send_item(make_point(-16'sd32768, -16'sd32768));
		send_item(make_point(16'sd32767, -16'sd1));
		send_item(make_box(-16'sd10, -16'sd10, 16'sd10, 16'sd10, 3'd0));
		send_item(make_point(16'sd0, 16'sd0));
		set_region(16'sd5, 16'sd5, 16'sd5, 16'sd5);
		send_item(make_box(16'sd5, 16'sd5, 16'sd5, 16'sd5, 3'd4));
		send_item(make_point(16'sd5, 16'sd5));
		send_item(make_point(16'sd6, 16'sd5));
		set_region(16'sd100, 16'sd100, -16'sd100, -16'sd100);
		send_item(make_box(-16'sd50, -16'sd50, 16'sd50, 16'sd50, 3'd2));
		send_item(make_point(16'sd0, 16'sd0));

		// random phases over several regions; the table fills and drops inserts
		set_region(-16'sd800, -16'sd400, 16'sd1200, 16'sd1600);
		random_phase(150, -16'sd800, -16'sd400, 16'sd1200, 16'sd1600);
		set_region(16'sd0, 16'sd0, 16'sd7, 16'sd3);
		random_phase(100, 16'sd0, 16'sd0, 16'sd7, 16'sd3);
		set_region(-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767);
		random_phase(150, -16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767);
		set_region(16'sd30000, -16'sd200, 16'sd32767, 16'sd200);
		random_phase(150, 16'sd30000, -16'sd200, 16'sd32767, 16'sd200);
		set_region(16'sd0, 16'sd0, 16'sd32767, 16'sd32767);
		random_phase(150, 16'sd0, 16'sd0, 16'sd32767, 16'sd32767);

		drain();
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// overall time limit
	initial begin
		#20000000;
		$display("Test completed with failures");
		$finish;
	end
endmodule
`default_nettype wire
